// ===== src/fdr_pkg.sv =====
// Package: shared types and constants for the Fresnel dielectric reflectance unit.
package fdr_pkg;

    localparam int RESULT_FRAC_BITS = 16;
    localparam int REFL_W           = RESULT_FRAC_BITS + 1;

    localparam int FRONT_STAGES = 5;
    localparam int SQRT_RAD_W   = 62;
    localparam int SQRT_ROOT_W  = SQRT_RAD_W / 2;
    localparam int MID_STAGES   = 1;
    localparam int DIV_Q_W      = 31;
    localparam int BACK_STAGES  = 3;
    localparam int PIPE_LATENCY = FRONT_STAGES + SQRT_ROOT_W + MID_STAGES + DIV_Q_W + BACK_STAGES;

    localparam int NP_W = 49;
    localparam int NQ_W = 33;

    typedef struct packed {
        logic signed [15:0] cos_incident;
        logic [15:0]        eta_incident;
        logic [15:0]        eta_transmit;
    } request_t;

    typedef struct packed {
        logic [REFL_W-1:0] reflectance;
        logic              total_internal;
    } result_t;

    typedef struct packed {
        logic        tir;
        logic [15:0] ei;
        logic [47:0] x;
        logic [31:0] a;
    } front_side_t;

endpackage

// ===== src/fresnel_dielectric_reflectance_unit.sv =====
// Top level: unpolarized Fresnel reflectance at a dielectric boundary.
//
//  channel | ports                        | handshake
//  --------+------------------------------+----------------------------------
//  request | start, busy, request         | taken when start && !busy
//  result  | result_valid, result         | one-cycle strobe, no back-pressure
//
// One request per cycle; busy is always low. The pipeline has 5 front stages,
// 31 square-root stages, 1 ratio setup stage, 31 divider stages and 3 back
// stages. Reset clears only the valid bits.
// Nothing stalls: each result leaves exactly once, in request order.
module fresnel_dielectric_reflectance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fdr_pkg::request_t request,
    output logic              result_valid,
    output fdr_pkg::result_t  result
);

    localparam int SIDE_W = $bits(fdr_pkg::front_side_t);

    logic                  f_valid;
    logic [61:0]           f_rad;
    fdr_pkg::front_side_t  f_side;

    logic                  s_valid;
    logic [30:0]           s_root;
    fdr_pkg::front_side_t  s_side;

    logic                  m_valid_reg;
    logic                  m_tir_reg;
    logic [fdr_pkg::NP_W-1:0] m_np_reg, m_dp_reg;
    logic [fdr_pkg::NQ_W-1:0] m_nq_reg, m_dq_reg;

    logic [46:0] y;
    logic [48:0] xe, ye;
    logic [32:0] ae, se;

    logic        dp_valid, dq_valid, dp_tir, dq_side;
    logic [31:0] rp, rq;

    assign busy = 1'b0;

    fdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (request),
        .out_valid (f_valid),
        .radicand  (f_rad),
        .side      (f_side)
    );

    fdr_sqrt #(
        .RAD_W  (fdr_pkg::SQRT_RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .radicand  (f_rad),
        .side_in   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    always_comb
    begin
        y  = s_side.ei * s_root;
        xe = {1'b0, s_side.x};
        ye = {2'b00, y};
        ae = {1'b0, s_side.a};
        se = {2'b00, s_root};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tir_reg <= s_side.tir;
        m_np_reg  <= (xe > ye) ? xe - ye : ye - xe;
        m_dp_reg  <= xe + ye;
        m_nq_reg  <= (ae > se) ? ae - se : se - ae;
        m_dq_reg  <= ae + se;
    end

    fdr_div #(
        .NUM_W  (fdr_pkg::NP_W),
        .Q_W    (fdr_pkg::DIV_Q_W),
        .SIDE_W (1)
    ) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .num       (m_np_reg),
        .den       (m_dp_reg),
        .side_in   (m_tir_reg),
        .out_valid (dp_valid),
        .quot      (rp),
        .side_out  (dp_tir)
    );

    fdr_div #(
        .NUM_W  (fdr_pkg::NQ_W),
        .Q_W    (fdr_pkg::DIV_Q_W),
        .SIDE_W (1)
    ) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .num       (m_nq_reg),
        .den       (m_dq_reg),
        .side_in   (m_valid_reg),
        .out_valid (dq_valid),
        .quot      (rq),
        .side_out  (dq_side)
    );

    fdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dp_valid && dq_valid && dq_side),
        .rp        (rp),
        .rq        (rq),
        .tir       (dp_tir),
        .out_valid (result_valid),
        .res       (result)
    );

endmodule

// ===== src/fdr_front.sv =====
// Front end: sign fold, index squares, Snell test and sqrt radicand.
module fdr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fdr_pkg::request_t   req,
    output logic                out_valid,
    output logic [61:0]         radicand,
    output fdr_pkg::front_side_t side
);

    logic [4:0]  vld_reg;
    logic [15:0] a_ci_reg, a_ei_reg, a_et_reg;
    logic [31:0] b_ci2_reg, b_ei2_reg, b_et2_reg;
    logic [15:0] b_ci_reg, b_ei_reg;
    logic [30:0] c_sin2_reg;
    logic [31:0] c_ei2_reg, c_et2_reg;
    logic [15:0] c_ei_reg;
    logic [47:0] c_x_reg;
    logic [31:0] c_a_reg;
    logic [63:0] d_lhs_reg;
    logic [61:0] d_rhs_reg;
    logic [15:0] d_ei_reg;
    logic [47:0] d_x_reg;
    logic [31:0] d_a_reg;
    logic [61:0] e_rad_reg;
    fdr_pkg::front_side_t e_side_reg;

    logic [15:0] ei_fix, et_fix, ci_next;
    logic        leaving;
    logic        tir_next;

    always_comb
    begin
        ei_fix  = (req.eta_incident == 16'd0) ? 16'd1 : req.eta_incident;
        et_fix  = (req.eta_transmit == 16'd0) ? 16'd1 : req.eta_transmit;
        leaving = !(req.cos_incident > 16'sd0);
        ci_next = leaving ? 16'(-req.cos_incident) : 16'(req.cos_incident);
        tir_next = d_lhs_reg >= {2'b00, d_rhs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_ci_reg <= ci_next;
        a_ei_reg <= leaving ? et_fix : ei_fix;
        a_et_reg <= leaving ? ei_fix : et_fix;

        b_ci2_reg <= a_ci_reg * a_ci_reg;
        b_ei2_reg <= a_ei_reg * a_ei_reg;
        b_et2_reg <= a_et_reg * a_et_reg;
        b_ci_reg  <= a_ci_reg;
        b_ei_reg  <= a_ei_reg;

        c_sin2_reg <= 31'(32'h4000_0000 - b_ci2_reg);
        c_ei2_reg  <= b_ei2_reg;
        c_et2_reg  <= b_et2_reg;
        c_ei_reg   <= b_ei_reg;
        c_x_reg    <= b_et2_reg * b_ci_reg;
        c_a_reg    <= b_ei_reg * b_ci_reg;

        d_lhs_reg <= c_ei2_reg * {1'b0, c_sin2_reg};
        d_rhs_reg <= {c_et2_reg, 30'd0};
        d_ei_reg  <= c_ei_reg;
        d_x_reg   <= c_x_reg;
        d_a_reg   <= c_a_reg;

        e_rad_reg       <= tir_next ? '0 : 62'(({2'b00, d_rhs_reg}) - d_lhs_reg);
        e_side_reg.tir  <= tir_next;
        e_side_reg.ei   <= d_ei_reg;
        e_side_reg.x    <= d_x_reg;
        e_side_reg.a    <= d_a_reg;
    end

    assign out_valid = vld_reg[4];
    assign radicand  = e_rad_reg;
    assign side      = e_side_reg;

endmodule

// ===== src/fdr_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module fdr_sqrt #(
    parameter int RAD_W  = 62,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int N     = RAD_W / 2;
    localparam int REM_W = N + 2;

    logic [N-1:0]      vld_reg;
    logic [RAD_W-1:0]  rad_reg  [N];
    logic [REM_W-1:0]  rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [SIDE_W-1:0] side_reg [N];

    logic              vld_in  [N+1];
    logic [RAD_W-1:0]  rad_in  [N+1];
    logic [REM_W-1:0]  rem_in  [N+1];
    logic [N-1:0]      root_in [N+1];
    logic [SIDE_W-1:0] side_s  [N+1];

    assign vld_in[0]  = in_valid;
    assign rad_in[0]  = radicand;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign side_s[0]  = side_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            rem_sh = {rem_in[i][REM_W-3:0], rad_in[i][RAD_W-1:RAD_W-2]};
            trial  = {root_in[i], 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= {rad_in[i][RAD_W-3:0], 2'b00};
            rem_reg[i]  <= ge ? REM_W'(rem_sh - trial) : rem_sh;
            root_reg[i] <= {root_in[i][N-2:0], ge};
            side_reg[i] <= side_s[i];
        end

        assign vld_in[i+1]  = vld_reg[i];
        assign rad_in[i+1]  = rad_reg[i];
        assign rem_in[i+1]  = rem_reg[i];
        assign root_in[i+1] = root_reg[i];
        assign side_s[i+1]  = side_reg[i];
    end

    assign out_valid = vld_in[N];
    assign root      = root_in[N];
    assign side_out  = side_s[N];

endmodule

// ===== src/fdr_div.sv =====
// Pipelined restoring divider: floor(n * 2^Q_W / d) for n <= d, one bit per stage.
module fdr_div #(
    parameter int NUM_W  = 49,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     num,
    input  logic [NUM_W-1:0]     den,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [Q_W:0]         quot,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int SW = SIDE_W + 2;

    logic [Q_W-1:0]   vld_reg;
    logic [NUM_W-1:0] rem_reg  [Q_W];
    logic [NUM_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W];
    logic [SW-1:0]    side_reg [Q_W];

    logic             vld_in [Q_W+1];
    logic [NUM_W-1:0] rem_in [Q_W+1];
    logic [NUM_W-1:0] den_in [Q_W+1];
    logic [Q_W-1:0]   q_in   [Q_W+1];
    logic [SW-1:0]    side_s [Q_W+1];

    assign vld_in[0] = in_valid;
    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign q_in[0]   = '0;
    assign side_s[0] = {side_in, den == '0, num >= den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end
    end

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [NUM_W:0] rem2;
        logic           ge;

        always_comb
        begin
            rem2 = {rem_in[i], 1'b0};
            ge   = rem2 >= {1'b0, den_in[i]};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? NUM_W'(rem2 - {1'b0, den_in[i]}) : NUM_W'(rem2);
            den_reg[i]  <= den_in[i];
            q_reg[i]    <= {q_in[i][Q_W-2:0], ge};
            side_reg[i] <= side_s[i];
        end

        assign vld_in[i+1] = vld_reg[i];
        assign rem_in[i+1] = rem_reg[i];
        assign den_in[i+1] = den_reg[i];
        assign q_in[i+1]   = q_reg[i];
        assign side_s[i+1] = side_reg[i];
    end

    always_comb
    begin
        if (side_s[Q_W][1])
        begin
            quot = '0;
        end
        else if (side_s[Q_W][0])
        begin
            quot = {1'b1, {Q_W{1'b0}}};
        end
        else
        begin
            quot = {1'b0, q_in[Q_W]};
        end
    end

    assign out_valid = vld_in[Q_W];
    assign side_out  = side_s[Q_W][SW-1:2];

endmodule

// ===== src/fdr_back.sv =====
// Back end: square the two ratios, sum, round and select the total reflection case.
module fdr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       rp,
    input  logic [31:0]       rq,
    input  logic              tir,
    output logic              out_valid,
    output fdr_pkg::result_t  res
);

    localparam int F = fdr_pkg::RESULT_FRAC_BITS;

    logic [2:0]  vld_reg;
    logic [63:0] g_rp2_reg, g_rq2_reg;
    logic        g_tir_reg, h_tir_reg;
    logic [63:0] h_sum_reg;
    fdr_pkg::result_t res_reg;

    logic [64:0] rounded;

    always_comb
    begin
        rounded = {1'b0, h_sum_reg} + (65'd1 << (62 - F));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        g_rp2_reg <= rp * rp;
        g_rq2_reg <= rq * rq;
        g_tir_reg <= tir;

        h_sum_reg <= g_rp2_reg + g_rq2_reg;
        h_tir_reg <= g_tir_reg;

        res_reg.total_internal <= h_tir_reg;
        res_reg.reflectance    <= h_tir_reg ? fdr_pkg::REFL_W'(1 << F)
                                            : rounded[63:63-F];
    end

    assign out_valid = vld_reg[2];
    assign res       = res_reg;

endmodule

// ===== src/fdr_checker.sv =====
// Checker: port-level properties of the reflectance unit, bound to the top level.
module fdr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input fdr_pkg::request_t request,
    input logic              result_valid,
    input fdr_pkg::result_t  result
);

    localparam int F = fdr_pkg::RESULT_FRAC_BITS;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(fdr_pkg::PIPE_LATENCY) result_valid)
        else $error("request did not produce a result on time");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, fdr_pkg::PIPE_LATENCY))
        else $error("result without a matching request");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.reflectance[F] || result.reflectance[F-1:0] == '0))
        else $error("reflectance above one");

    a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.total_internal) |-> result.reflectance[F])
        else $error("total internal reflection without unit reflectance");

    a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(request))
        else $error("request has unknown bits");

endmodule

bind fresnel_dielectric_reflectance_unit fdr_checker u_fdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

// ===== tb/tb_fresnel_dielectric_reflectance_unit.sv =====
// Testbench: Fresnel dielectric reflectance unit, random and directed requests checked in order.
module tb_fresnel_dielectric_reflectance_unit;

    timeunit 1ns;
    timeprecision 1ps;

    class reflectance_board;
        fdr_pkg::result_t pending[$];
        int               errors;

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned frac_q31(longint unsigned n, longint unsigned d);
            longint unsigned rem;
            longint unsigned q;
            rem = n;
            q = 0;
            if (d == 0)
                return 0;
            if (n >= d)
                return 64'd1 << 31;
            for (int i = 0; i < 31; i++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= d)
                begin
                    rem -= d;
                    q |= 1;
                end
            end
            return q;
        endfunction

        function fdr_pkg::result_t fresnel(fdr_pkg::request_t rq);
            longint signed    c;
            longint unsigned  ei, et, t, ci, sin2, lhs, rhs, s, x, y;
            longint unsigned  np, dp, a, nq, dq, rp, rr, sum;
            fdr_pkg::result_t r;
            c = rq.cos_incident;
            ei = rq.eta_incident == 0 ? 1 : rq.eta_incident;
            et = rq.eta_transmit == 0 ? 1 : rq.eta_transmit;
            if (c > 0)
                ci = c;
            else
            begin
                t = ei;
                ei = et;
                et = t;
                ci = -c;
            end
            sin2 = (64'd1 << 30) - ci * ci;
            lhs = ei * ei * sin2;
            rhs = (et * et) << 30;
            if (lhs >= rhs)
            begin
                r.reflectance = fdr_pkg::REFL_W'(1 << fdr_pkg::RESULT_FRAC_BITS);
                r.total_internal = 1'b1;
                return r;
            end
            s = isqrt(rhs - lhs);
            x = et * et * ci;
            y = ei * s;
            np = x > y ? x - y : y - x;
            dp = x + y;
            a = ei * ci;
            nq = a > s ? a - s : s - a;
            dq = a + s;
            rp = frac_q31(np, dp);
            rr = frac_q31(nq, dq);
            sum = rp * rp + rr * rr;
            sum = (sum + (64'd1 << (62 - fdr_pkg::RESULT_FRAC_BITS)))
                  >> (63 - fdr_pkg::RESULT_FRAC_BITS);
            r.reflectance = sum[fdr_pkg::REFL_W-1:0];
            r.total_internal = 1'b0;
            return r;
        endfunction

        function void note_request(fdr_pkg::request_t rq);
            pending.push_back(fresnel(rq));
        endfunction

        function void check_result(fdr_pkg::result_t got);
            fdr_pkg::result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.reflectance !== exp_r.reflectance)
            begin
                $error("reflectance exp %0d got %0d", exp_r.reflectance, got.reflectance);
                errors++;
            end
            if (got.total_internal !== exp_r.total_internal)
            begin
                $error("total_internal exp %0d got %0d", exp_r.total_internal,
                    got.total_internal);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    fdr_pkg::request_t request;
    logic              result_valid;
    fdr_pkg::result_t  result;

    reflectance_board board;
    int unsigned      cycles;

    fresnel_dielectric_reflectance_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("tb_fresnel_dielectric_reflectance_unit: done, errors");
            $finish;
        end
    end

    task automatic send_request(fdr_pkg::request_t rq, bit allow_gaps);
        int gap;
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(rq);
    endtask

    function automatic fdr_pkg::request_t random_request();
        fdr_pkg::request_t rq;
        case ($urandom_range(0, 5))
            0: rq.cos_incident = $urandom_range(0, 3) == 0 ? 16'sh8000 : 16'sh7fff;
            1: rq.cos_incident = 16'($urandom_range(0, 64) - 32);
            default: rq.cos_incident = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: rq.eta_incident = 16'($urandom);
            1: rq.eta_incident = 16'($urandom_range(0, 3));
            default: rq.eta_incident = 16'($urandom_range(4096, 12288));
        endcase
        case ($urandom_range(0, 4))
            0: rq.eta_transmit = 16'($urandom);
            1: rq.eta_transmit = 16'(32'hffff - $urandom_range(0, 3));
            default: rq.eta_transmit = 16'($urandom_range(4096, 12288));
        endcase
        return rq;
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        fdr_pkg::request_t rq;
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: cosine +-1, zero, tiny; index 0, 1, max; TIR
        for (int k = 0; k < 20; k++)
        begin
            case (k % 5)
                0: rq.cos_incident = 16'sh7fff;
                1: rq.cos_incident = 16'sh8000;
                2: rq.cos_incident = 16'sh0000;
                3: rq.cos_incident = 16'sh0001;
                default: rq.cos_incident = 16'shffff;
            endcase
            case (k / 5)
                0:
                begin
                    rq.eta_incident = 16'd4096;
                    rq.eta_transmit = 16'd6144;
                end
                1:
                begin
                    rq.eta_incident = 16'd0;
                    rq.eta_transmit = 16'hffff;
                end
                2:
                begin
                    rq.eta_incident = 16'hffff;
                    rq.eta_transmit = 16'd1;
                end
                default:
                begin
                    rq.eta_incident = 16'd6144;
                    rq.eta_transmit = 16'd6144;
                end
            endcase
            send_request(rq, 1'b0);
        end
        start <= 1'b0;
        wait_drained();

        for (int n = 0; n < 950; n++)
        begin
            if (n == 400)
            begin
                start <= 1'b0;
                wait_drained();
            end
            send_request(random_request(), n < 800);
        end
        start <= 1'b0;
        wait_drained();
        repeat (fdr_pkg::PIPE_LATENCY + 10) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_fresnel_dielectric_reflectance_unit: done, clean");
        else
            $display("tb_fresnel_dielectric_reflectance_unit: done, errors");
        $finish;
    end
endmodule
